// ----- design/sorted_interval_merge_core_defines.svh -----
// Assertion macros shared by the merge core RTL.
// Included by files that carry concurrent assertions.
`ifndef SORTED_INTERVAL_MERGE_CORE_DEFINES_SVH
`define SORTED_INTERVAL_MERGE_CORE_DEFINES_SVH

// check that a property holds at every edge out of reset
`define SIM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// check that a condition is followed by another (non-overlapping implication)
`define SIM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/sim_pkg.sv -----
// Types and float compare helpers for the sorted interval merge core.
// No dependencies.
`timescale 1ns / 1ps
package sim_pkg;

    typedef struct packed {
        logic        stream_id;
        logic        is_end;
        logic [63:0] key;
        logic [63:0] lo;
        logic [63:0] hi;
    } in_item_t;

    typedef struct packed {
        logic        record_valid;
        logic [63:0] out_key;
        logic [63:0] out_lo;
        logic [63:0] out_hi;
        logic        all_done;
        logic        next_stream;
    } out_item_t;

    function automatic logic is_nan(input logic [63:0] a);
        is_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
    endfunction

    function automatic logic f_eq(input logic [63:0] a, input logic [63:0] b);
        if (is_nan(a) || is_nan(b))
            f_eq = 1'b0;
        else
            f_eq = (a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0));
    endfunction

    // a < b as doubles
    function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
        if (is_nan(a) || is_nan(b) || f_eq(a, b))
            f_lt = 1'b0;
        else if (a[63] != b[63])
            f_lt = a[63];
        else if (a[63])
            f_lt = a[62:0] > b[62:0];
        else
            f_lt = a[62:0] < b[62:0];
    endfunction

endpackage

// ----- design/sim_step.sv -----
// Merge step logic: head/accumulator next state and result item.
// Depends on sim_pkg.
`timescale 1ns / 1ps
module sim_step (
    input  sim_pkg::in_item_t  item,
    input  logic               acc_valid,
    input  logic [63:0]        acc_key,
    input  logic [63:0]        acc_lo,
    input  logic [63:0]        acc_hi,
    input  logic [1:0]         head_valid,
    input  logic [1:0][63:0]   head_key,
    input  logic [1:0][63:0]   head_lo,
    input  logic [1:0][63:0]   head_hi,
    input  logic [1:0]         ended,
    output logic               acc_valid_n,
    output logic [63:0]        acc_key_n,
    output logic [63:0]        acc_lo_n,
    output logic [63:0]        acc_hi_n,
    output logic [1:0]         head_valid_n,
    output logic [1:0][63:0]   head_key_n,
    output logic [1:0][63:0]   head_lo_n,
    output logic [1:0][63:0]   head_hi_n,
    output logic [1:0]         ended_n,
    output sim_pkg::out_item_t res
);
    import sim_pkg::*;

    logic [1:0] hv;
    logic [1:0] res_ok;
    logic       sel;

    always_comb
    begin
        hv           = head_valid;
        head_key_n   = head_key;
        head_lo_n    = head_lo;
        head_hi_n    = head_hi;
        ended_n      = ended;
        acc_valid_n  = acc_valid;
        acc_key_n    = acc_key;
        acc_lo_n     = acc_lo;
        acc_hi_n     = acc_hi;
        res          = '0;
        sel          = 1'b0;
        if (!(hv[item.stream_id] || ended[item.stream_id]))
        begin
            if (item.is_end)
                ended_n[item.stream_id] = 1'b1;
            else
            begin
                hv[item.stream_id]         = 1'b1;
                head_key_n[item.stream_id] = item.key;
                head_lo_n[item.stream_id]  = item.lo;
                head_hi_n[item.stream_id]  = item.hi;
            end
        end
        res_ok = hv | ended_n;
        if (res_ok == 2'b11)
        begin
            if (acc_valid && hv[0] && f_eq(head_key_n[0], acc_key))
                sel = 1'b0;
            else
                sel = 1'b1;
            if (acc_valid && ((hv[0] && f_eq(head_key_n[0], acc_key))
                || (hv[1] && f_eq(head_key_n[1], acc_key))))
            begin
                if (f_lt(acc_lo, head_lo_n[sel]))
                    acc_lo_n = head_lo_n[sel];
                if (f_lt(head_hi_n[sel], acc_hi))
                    acc_hi_n = head_hi_n[sel];
                hv[sel] = 1'b0;
            end
            else
            begin
                if (acc_valid)
                begin
                    res.record_valid = 1'b1;
                    res.out_key      = acc_key;
                    res.out_lo       = acc_lo;
                    res.out_hi       = acc_hi;
                    acc_valid_n      = 1'b0;
                end
                if (hv != 2'b00)
                begin
                    if (hv == 2'b11)
                        sel = f_lt(head_key_n[1], head_key_n[0]);
                    else
                        sel = hv[1];
                    acc_valid_n = 1'b1;
                    acc_key_n   = head_key_n[sel];
                    acc_lo_n    = head_lo_n[sel];
                    acc_hi_n    = head_hi_n[sel];
                    hv[sel]     = 1'b0;
                end
            end
        end
        head_valid_n    = hv;
        res.all_done    = (ended_n == 2'b11) && (hv == 2'b00) && !acc_valid_n;
        res.next_stream = (hv[0] || ended_n[0]) && !(hv[1] || ended_n[1]);
    end
endmodule

// ----- design/sorted_interval_merge_core.sv -----
// Top level of the sorted interval merge core: state and output registers.
// Depends on sim_pkg, sim_step and the assertion macro header.
// Each accepted item's result is registered and shows in the cycle after it is taken.
// One item per cycle unless stalled; step logic is between state and result register.
// Reset: async active low; clears heads, accumulator, end flags and output valid.
`timescale 1ns / 1ps
`include "sorted_interval_merge_core_defines.svh"
module sorted_interval_merge_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sim_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sim_pkg::out_item_t out_data
);
    import sim_pkg::*;

    logic              acc_valid_reg, acc_valid_next;
    logic [63:0]       acc_key_reg, acc_key_next, acc_lo_reg, acc_lo_next;
    logic [63:0]       acc_hi_reg, acc_hi_next;
    logic [1:0]        head_valid_reg, head_valid_next, ended_reg, ended_next;
    logic [1:0][63:0]  head_key_reg, head_key_next, head_lo_reg, head_lo_next;
    logic [1:0][63:0]  head_hi_reg, head_hi_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg, res;
    logic              take;
    logic              done_out;

    assign in_stall  = out_valid_reg && out_stall;
    assign take      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign done_out  = out_valid && out_data.all_done;

    sim_step u_step (
        .item(in_data), .acc_valid(acc_valid_reg), .acc_key(acc_key_reg),
        .acc_lo(acc_lo_reg), .acc_hi(acc_hi_reg), .head_valid(head_valid_reg),
        .head_key(head_key_reg), .head_lo(head_lo_reg), .head_hi(head_hi_reg),
        .ended(ended_reg), .acc_valid_n(acc_valid_next), .acc_key_n(acc_key_next),
        .acc_lo_n(acc_lo_next), .acc_hi_n(acc_hi_next),
        .head_valid_n(head_valid_next), .head_key_n(head_key_next),
        .head_lo_n(head_lo_next), .head_hi_n(head_hi_next),
        .ended_n(ended_next), .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg  <= 1'b0;
            acc_key_reg    <= '0;
            acc_lo_reg     <= '0;
            acc_hi_reg     <= '0;
            head_valid_reg <= '0;
            head_key_reg   <= '0;
            head_lo_reg    <= '0;
            head_hi_reg    <= '0;
            ended_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                acc_valid_reg  <= acc_valid_next;
                acc_key_reg    <= acc_key_next;
                acc_lo_reg     <= acc_lo_next;
                acc_hi_reg     <= acc_hi_next;
                head_valid_reg <= head_valid_next;
                head_key_reg   <= head_key_next;
                head_lo_reg    <= head_lo_next;
                head_hi_reg    <= head_hi_next;
                ended_reg      <= ended_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= res;
    end

    `SIM_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall, out_valid && $stable(out_data))
    `SIM_ASSERT(a_done_empty, done_out |-> !acc_valid_reg && head_valid_reg == 2'b00)
    `SIM_ASSERT_NEXT(a_end_sticky, take, (ended_reg & $past(ended_reg)) == $past(ended_reg))
endmodule
